@@ rtl/core/lnr_pkg.sv @@
// ---------------------------------------------------------------------------
// lnr_pkg
// Shared types and constants of the layer normalization row unit.
// ---------------------------------------------------------------------------
package lnr_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int DATA_W       = 16;
    localparam int ROW_LEN_W    = 7;
    localparam int EPS_W        = 16;
    localparam int RSTD_W       = 24;
    localparam int VAR_W        = 35;
    localparam int DIV_NW       = 49;
    localparam int DIV_DW       = 36;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [RSTD_W-1:0] RSTD_MAX = {RSTD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SHIFT = 2'd3;

    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = 7'd64;
    localparam logic [EPS_W-1:0]     EPS_RST     = 16'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] scale_value;
        logic signed [DATA_W-1:0] shift_value;
    } t_lnr_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_value;
        logic signed [DATA_W-1:0] row_mean;
        logic [RSTD_W-1:0]        row_rstd;
        logic                     last_of_row;
    } t_lnr_out;

    typedef enum logic [1:0] {
        RD_SUM,
        RD_SQ,
        RD_EMIT
    } t_rd_kind;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_RECIP
    } t_div_sel;

    typedef struct packed {
        logic     rd_en;
        t_rd_kind rd_kind;
        logic     clr;
        logic     emit_last;
        logic     div_start;
        t_div_sel div_sel;
    } t_lnr_cmd;

    typedef struct packed {
        logic calc_busy;
        logic pipe_busy;
        logic out_busy;
    } t_lnr_sts;

endpackage

@@ rtl/core/lnr_ram.sv @@
// ---------------------------------------------------------------------------
// lnr_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/lnr_ctrl.sv @@
// ---------------------------------------------------------------------------
// lnr_ctrl
// Row sequencer: load, sum pass, mean divide, square pass, variance and
// reciprocal divide plus square root, then element emit.
// ---------------------------------------------------------------------------
module lnr_ctrl #(
    parameter int MAX_COLS = lnr_pkg::MAX_COLS_DEF,
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int LW = $clog2(MAX_COLS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lnr_pkg::ROW_LEN_W-1:0]      i_row_len,
    input  lnr_pkg::t_lnr_sts                  i_sts,
    output lnr_pkg::t_lnr_cmd                  o_cmd,
    output logic [AW-1:0]                      o_rd_addr,
    output logic [AW-1:0]                      o_wr_addr,
    output logic [LW-1:0]                      o_len
);
    import lnr_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SUM,
        S_SUM_WAIT,
        S_MDIV,
        S_SQ,
        S_SQ_WAIT,
        S_VDIV,
        S_RDIV,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state        r_state, n_state;
    t_lnr_cmd      r_cmd, n_cmd;
    logic [AW-1:0] r_addr, n_addr;
    logic [LW-1:0] r_k, n_k;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] w_len;
    logic          w_accept;

    // zero counts as one, anything above the store depth clamps
    always_comb begin
        if (i_row_len == '0) begin
            w_len = LW'(1);
        end else if (32'(i_row_len) > MAX_COLS) begin
            w_len = LW'(MAX_COLS);
        end else begin
            w_len = LW'(i_row_len);
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        n_addr  = r_addr;
        n_k     = r_k;
        n_fill  = r_fill;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if ((r_fill + LW'(1)) >= w_len) begin
                        n_fill        = '0;
                        n_cmd.rd_en   = 1'b1;
                        n_cmd.rd_kind = RD_SUM;
                        n_cmd.clr     = 1'b1;
                        n_addr        = '0;
                        n_k           = LW'(1);
                        n_state       = (w_len == LW'(1)) ? S_SUM_WAIT : S_SUM;
                    end else begin
                        n_fill = r_fill + LW'(1);
                    end
                end
            end
            S_SUM, S_SQ: begin
                n_cmd.rd_en   = 1'b1;
                n_cmd.rd_kind = (r_state == S_SUM) ? RD_SUM : RD_SQ;
                n_addr        = r_k[AW-1:0];
                if (r_k == w_len - LW'(1)) begin
                    n_state = (r_state == S_SUM) ? S_SUM_WAIT : S_SQ_WAIT;
                end else begin
                    n_k = r_k + LW'(1);
                end
            end
            S_SUM_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    n_cmd.div_start = 1'b1;
                    n_cmd.div_sel   = DIV_MEAN;
                    n_state         = S_MDIV;
                end
            end
            S_MDIV: begin
                if (!i_sts.calc_busy) begin
                    n_cmd.rd_en   = 1'b1;
                    n_cmd.rd_kind = RD_SQ;
                    n_addr        = '0;
                    n_k           = LW'(1);
                    n_state       = (w_len == LW'(1)) ? S_SQ_WAIT : S_SQ;
                end
            end
            S_SQ_WAIT: begin
                if (!i_sts.pipe_busy) begin
                    n_cmd.div_start = 1'b1;
                    n_cmd.div_sel   = DIV_VAR;
                    n_state         = S_VDIV;
                end
            end
            S_VDIV: begin
                if (!i_sts.calc_busy) begin
                    n_cmd.div_start = 1'b1;
                    n_cmd.div_sel   = DIV_RECIP;
                    n_state         = S_RDIV;
                end
            end
            S_RDIV: begin
                // waits for the reciprocal divide and the square root
                if (!i_sts.calc_busy) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.pipe_busy && !i_sts.out_busy) begin
                    n_cmd.rd_en     = 1'b1;
                    n_cmd.rd_kind   = RD_EMIT;
                    n_cmd.emit_last = (r_k == w_len - LW'(1));
                    n_addr          = r_k[AW-1:0];
                    if (r_k == w_len - LW'(1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_k = r_k + LW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cmd   <= '0;
            r_k     <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_k     <= n_k;
            r_fill  <= n_fill;
        end
        r_addr <= n_addr;
    end

    assign o_in_ready = (r_state == S_LOAD);
    assign o_cmd      = r_cmd;
    assign o_rd_addr  = r_addr;
    assign o_wr_addr  = r_fill[AW-1:0];
    assign o_len      = w_len;
endmodule

@@ rtl/core/lnr_dpath.sv @@
// ---------------------------------------------------------------------------
// lnr_dpath
// Element store, sum and square accumulators, shared bit-serial divider,
// square root unit and the emit multiply pipeline with output register.
// ---------------------------------------------------------------------------
module lnr_dpath #(
    parameter int MAX_COLS = lnr_pkg::MAX_COLS_DEF,
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int LW = $clog2(MAX_COLS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  lnr_pkg::t_lnr_in             i_in,
    input  lnr_pkg::t_lnr_cmd            i_cmd,
    input  logic [AW-1:0]                i_rd_addr,
    input  logic [LW-1:0]                i_len,
    input  logic [lnr_pkg::EPS_W-1:0]    i_eps,
    input  logic                         i_use_scale,
    input  logic                         i_use_shift,
    output lnr_pkg::t_lnr_sts            o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output lnr_pkg::t_lnr_out            o_out
);
    import lnr_pkg::*;

    localparam int SUM_W   = DATA_W + AW + 1;
    localparam int SUMSQ_W = 2 * (DATA_W + 1) + AW;
    localparam int DCW     = $clog2(DIV_NW);
    localparam int MEM_W   = 3 * DATA_W;

    // element store
    logic [MEM_W-1:0]         w_q;
    logic signed [DATA_W-1:0] w_qx, w_qg, w_qb;

    lnr_ram #(.WIDTH(MEM_W), .DEPTH(MAX_COLS)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata ({i_in.shift_value, i_in.scale_value, i_in.x_value}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_q)
    );

    assign w_qx = w_q[DATA_W-1:0];
    assign w_qg = w_q[2*DATA_W-1:DATA_W];
    assign w_qb = w_q[3*DATA_W-1:2*DATA_W];

    // read data valid flags, one per pass kind
    logic r_s1, r_q1, r_q2, r_e1, r_last1;

    logic signed [SUM_W-1:0]  r_sum;
    logic [SUMSQ_W-1:0]       r_sumsq;
    logic signed [DATA_W-1:0] r_mean;
    logic [VAR_W-1:0]         r_var;
    logic [RSTD_W-1:0]        r_rstd;
    logic [2*DATA_W+1:0]      r_sqd;

    logic signed [DATA_W:0]     w_dq;
    logic signed [2*DATA_W+1:0] w_sqp;
    logic [SUM_W-1:0]           w_sum_abs;
    logic [DIV_DW-1:0]          w_v;

    assign w_dq      = {w_qx[DATA_W-1], w_qx} - {r_mean[DATA_W-1], r_mean};
    assign w_sqp     = w_dq * w_dq;
    assign w_sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_v       = DIV_DW'(r_var) + DIV_DW'(i_eps);

    // restoring divider, one quotient bit per cycle
    logic              r_div_busy;
    t_div_sel          r_div_sel;
    logic [DCW-1:0]    r_div_cnt;
    logic [DIV_NW-1:0] r_num, n_num;
    logic [DIV_DW-1:0] r_rem, n_rem, r_den;
    logic [DIV_DW:0]   w_trial;
    logic              w_ge;
    logic              r_mean_neg;

    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_ge ? DIV_DW'(w_trial - {1'b0, r_den}) : w_trial[DIV_DW-1:0];
    assign n_num   = {r_num[DIV_NW-2:0], w_ge};

    // integer square root, two radicand bits per cycle
    logic              r_sq_busy;
    logic [DIV_NW-1:0] r_sq_n, r_sq_bit;
    logic [DIV_NW:0]   r_sq_r, w_rb, n_sq_r;
    logic              w_sq_ge;

    assign w_rb    = r_sq_r + (DIV_NW + 1)'(r_sq_bit);
    assign w_sq_ge = ({1'b0, r_sq_n} >= w_rb);
    assign n_sq_r  = w_sq_ge ? ((r_sq_r >> 1) + (DIV_NW + 1)'(r_sq_bit)) : (r_sq_r >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_sq_busy  <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                r_rem     <= '0;
                r_div_cnt <= '0;
                r_div_sel <= i_cmd.div_sel;
                unique case (i_cmd.div_sel)
                    DIV_MEAN: begin
                        r_num      <= DIV_NW'(w_sum_abs) + DIV_NW'(i_len >> 1);
                        r_den      <= DIV_DW'(i_len);
                        r_mean_neg <= r_sum[SUM_W-1];
                        r_div_busy <= 1'b1;
                    end
                    DIV_VAR: begin
                        r_num      <= DIV_NW'(r_sumsq) + DIV_NW'(i_len >> 1);
                        r_den      <= DIV_DW'(i_len);
                        r_div_busy <= 1'b1;
                    end
                    DIV_RECIP: begin
                        r_den <= w_v;
                        if (w_v == '0) begin
                            r_rstd <= RSTD_MAX;
                        end else begin
                            r_num      <= DIV_NW'(1) << (DIV_NW - 1);
                            r_div_busy <= 1'b1;
                        end
                    end
                    default: begin
                        r_div_busy <= 1'b0;
                    end
                endcase
            end else if (r_div_busy) begin
                r_num     <= n_num;
                r_rem     <= n_rem;
                r_div_cnt <= r_div_cnt + DCW'(1);
                if (r_div_cnt == DCW'(DIV_NW - 1)) begin
                    r_div_busy <= 1'b0;
                    unique case (r_div_sel)
                        DIV_MEAN: begin
                            r_mean <= r_mean_neg ? DATA_W'(-n_num[DATA_W-1:0])
                                                 : n_num[DATA_W-1:0];
                        end
                        DIV_VAR: begin
                            r_var <= n_num[VAR_W-1:0];
                        end
                        DIV_RECIP: begin
                            r_sq_n    <= n_num;
                            r_sq_r    <= '0;
                            r_sq_bit  <= DIV_NW'(1) << (DIV_NW - 1);
                            r_sq_busy <= 1'b1;
                        end
                        default: begin
                            r_var <= r_var;
                        end
                    endcase
                end
            end
            if (r_sq_busy) begin
                if (w_sq_ge) begin
                    r_sq_n <= r_sq_n - w_rb[DIV_NW-1:0];
                end
                r_sq_r   <= n_sq_r;
                r_sq_bit <= r_sq_bit >> 2;
                if (r_sq_bit[0]) begin
                    r_sq_busy <= 1'b0;
                    r_rstd    <= (n_sq_r > (DIV_NW + 1)'(RSTD_MAX)) ? RSTD_MAX
                                                                  : n_sq_r[RSTD_W-1:0];
                end
            end
        end
    end

    // accumulation passes
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            if (r_s1) begin
                r_sum <= r_sum + SUM_W'(w_qx);
            end
            if (r_q2) begin
                r_sumsq <= r_sumsq + SUMSQ_W'(r_sqd);
            end
        end
        if (r_q1) begin
            r_sqd <= w_sqp;
        end
    end

    localparam int ACC_W = 2 * DATA_W + RSTD_W + 3;

    // emit pipeline: deviation, times rstd, times scale, add shift and round
    logic                       r_ea, r_eb, r_ec;
    logic                       r_la, r_lb, r_lc;
    logic signed [DATA_W:0]     r_d;
    logic signed [DATA_W-1:0]   r_ga, r_gb, r_ba, r_bb, r_bc;
    logic signed [RSTD_W:0]     w_rstd_s;
    logic signed [DATA_W+RSTD_W+1:0] r_p1;
    logic signed [2*DATA_W+RSTD_W+1:0] r_p2;
    logic signed [2*DATA_W+RSTD_W+2:0] w_acc;
    logic signed [ACC_W-RSTD_W-1:0]    w_yq;
    logic signed [DATA_W-1:0]   w_y;

    assign w_rstd_s = {1'b0, r_rstd};
    assign w_acc    = ACC_W'(r_p2) + (ACC_W'(r_bc) <<< RSTD_W)
                    + (ACC_W'(1) <<< (RSTD_W - 1));
    assign w_yq     = w_acc[ACC_W-1:RSTD_W];

    always_comb begin
        if (w_yq > (ACC_W - RSTD_W)'(32767)) begin
            w_y = 16'sh7fff;
        end else if (w_yq < -(ACC_W - RSTD_W)'(32768)) begin
            w_y = 16'sh8000;
        end else begin
            w_y = w_yq[DATA_W-1:0];
        end
    end

    logic                     r_out_valid, r_out_last;
    logic signed [DATA_W-1:0] r_out_y, r_out_mean;
    logic [RSTD_W-1:0]        r_out_rstd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= 1'b0;
            r_q1        <= 1'b0;
            r_q2        <= 1'b0;
            r_e1        <= 1'b0;
            r_ea        <= 1'b0;
            r_eb        <= 1'b0;
            r_ec        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_cmd.rd_en && (i_cmd.rd_kind == RD_SUM);
            r_q1 <= i_cmd.rd_en && (i_cmd.rd_kind == RD_SQ);
            r_e1 <= i_cmd.rd_en && (i_cmd.rd_kind == RD_EMIT);
            r_q2 <= r_q1;
            r_ea <= r_e1;
            r_eb <= r_ea;
            r_ec <= r_eb;
            if (r_ec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_last1 <= i_cmd.emit_last;
        if (r_e1) begin
            r_d  <= w_dq;
            r_ga <= i_use_scale ? w_qg : 16'sd256;
            r_ba <= i_use_shift ? w_qb : 16'sd0;
            r_la <= r_last1;
        end
        r_p1 <= r_d * w_rstd_s;
        r_gb <= r_ga;
        r_bb <= r_ba;
        r_lb <= r_la;
        r_p2 <= r_p1 * r_gb;
        r_bc <= r_bb;
        r_lc <= r_lb;
        if (r_ec) begin
            r_out_y    <= w_y;
            r_out_mean <= r_mean;
            r_out_rstd <= r_rstd;
            r_out_last <= r_lc;
        end
    end

    assign o_sts.calc_busy = r_div_busy || r_sq_busy || i_cmd.div_start;
    assign o_sts.pipe_busy = i_cmd.rd_en || r_s1 || r_q1 || r_q2 || r_e1
                           || r_ea || r_eb || r_ec;
    assign o_sts.out_busy  = r_out_valid;

    assign o_out_valid       = r_out_valid;
    assign o_out.y_value     = r_out_y;
    assign o_out.row_mean    = r_out_mean;
    assign o_out.row_rstd    = r_out_rstd;
    assign o_out.last_of_row = r_out_last;

    a_div_sqrt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_div_busy && r_sq_busy))
        else $error("divider and square root busy together");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (!r_div_busy && !r_sq_busy))
        else $error("divide started while arithmetic busy");

    a_one_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_s1, r_q1, r_e1}))
        else $error("read data claimed by two passes");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ec |-> !r_out_valid)
        else $error("result overwrites an untaken result");
endmodule

@@ rtl/core/layer_normalization_row_unit.sv @@
// ---------------------------------------------------------------------------
// layer_normalization_row_unit
// Layer normalization of one row of Q8.8 samples with per-column scale/shift.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in) carries one element per
// transfer: sample, scale and shift. Each element is written to the store.
// The transfer that completes the row starts the statistics:
//   sum pass
//   mean divide (shared bit-serial divider)
//   square pass
//   variance divide
//   reciprocal divide, then square root
// The emit phase then sends one result per row element on the output channel
// (o_out_valid/i_out_ready, o_out) through the multiply pipeline, one element
// in flight at a time, last_of_row on the final one. Input is not taken from
// the row's last element until all its results are issued. A stalled
// receiver holds the output register and emit waits; the held result keeps
// its own mean and rstd.
// Reset (i_rst_n low, synchronous) empties the row and restores defaults:
// row_len 64, eps_value 1, scale and shift disabled. Configuration is a
// plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) used only while idle;
// the user must keep to this, the block has no check for it.
// ---------------------------------------------------------------------------
module layer_normalization_row_unit #(
    parameter int MAX_COLS = lnr_pkg::MAX_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lnr_pkg::t_lnr_in                  i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lnr_pkg::t_lnr_out                 o_out,
    input  logic                              i_cfg_we,
    input  logic [lnr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lnr_pkg::CFG_W-1:0]         i_cfg_data
);
    import lnr_pkg::*;

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW = $clog2(MAX_COLS + 1);

    logic [ROW_LEN_W-1:0] r_row_len;
    logic [EPS_W-1:0]     r_eps;
    logic                 r_use_scale, r_use_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len   <= ROW_LEN_RST;
            r_eps       <= EPS_RST;
            r_use_scale <= 1'b0;
            r_use_shift <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_LEN:   r_row_len   <= i_cfg_data[ROW_LEN_W-1:0];
                CFG_EPS:       r_eps       <= i_cfg_data[EPS_W-1:0];
                CFG_USE_SCALE: r_use_scale <= i_cfg_data[0];
                CFG_USE_SHIFT: r_use_shift <= i_cfg_data[0];
                default:       r_eps       <= r_eps;
            endcase
        end
    end

    t_lnr_cmd      w_cmd;
    t_lnr_sts      w_sts;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [LW-1:0] w_len;

    lnr_ctrl #(.MAX_COLS(MAX_COLS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_row_len  (r_row_len),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr),
        .o_len      (w_len)
    );

    lnr_dpath #(.MAX_COLS(MAX_COLS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_in_valid && o_in_ready),
        .i_wr_addr   (w_wr_addr),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .i_len       (w_len),
        .i_eps       (r_eps),
        .i_use_scale (r_use_scale),
        .i_use_shift (r_use_shift),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule
